[sv/rbst_pkg.sv]
`default_nettype none

package rbst_pkg;

    localparam int CB = 32;
    localparam int FB = 16;
    localparam int THR_W = 16;
    localparam int LEN_W = CB - 1;
    localparam int PROD_W = CB + LEN_W;
    localparam int NUM_W = CB + FB;
    localparam int LANES = 3;
    localparam int LANE_LAT = NUM_W + 4;
    localparam int MERGE_LAT = 2;
    localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;
    localparam int IDX_W = 3;

    localparam logic [CB-1:0] MAX_MAG = {1'b0, {(CB - 1){1'b1}}};
    localparam logic [CB-1:0] MIN_MAG = {1'b1, {(CB - 1){1'b0}}};

    localparam logic [IDX_W-1:0] REG_BOX_MIN_X = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_BOX_MIN_Y = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_BOX_MIN_Z = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_BOX_MAX_X = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_BOX_MAX_Y = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_BOX_MAX_Z = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_THRESHOLD = IDX_W'(6);

    typedef struct packed {
        logic par;
        logic par_hit;
        logic neg1;
        logic neg2;
    } t_side;

    typedef struct packed {
        logic ok;
        logic signed [CB-1:0] tlo;
        logic signed [CB-1:0] thi;
    } t_lane_res;

    // Sign and magnitude to a saturated signed coordinate.
    function automatic logic signed [CB-1:0] sat_pack(input logic neg,
                                                      input logic [NUM_W-1:0] mag);
        logic [CB-1:0] m;
        if (!neg) begin
            m = (mag > NUM_W'(MAX_MAG)) ? MAX_MAG : mag[CB-1:0];
            return $signed(m);
        end
        m = (mag > NUM_W'(MIN_MAG)) ? MIN_MAG : mag[CB-1:0];
        return $signed(~m + CB'(1));
    endfunction

endpackage

`default_nettype wire

[sv/ray_box_slab_test.sv]
`default_nettype none

// Ray against axis-aligned box test, slab method, signed Q16.16.
// Configuration: write i_cfg_we with i_cfg_idx and i_cfg_data while the block
// is idle. Indexes 0 to 5 hold the box lower and upper corners (x, y, z),
// index 6 holds the parallel threshold in the low 16 bits; other indexes are
// ignored.
// Input: a ray transaction is taken at each clock edge with i_start high and
// o_busy low. o_busy is always low, so one ray can enter every cycle.
// Output: o_valid pulses for one cycle with o_hit for each ray, in order.
// Throughput is one ray per cycle. The pipeline is made of the two pipelined
// restoring dividers in each of the three axis lanes, one quotient bit per
// stage over 48 stages, plus two front stages, two lane finishing stages and
// two merge stages.
// The receiver cannot stall; every result is shown exactly once.
// Reset clears the valid pipeline, so no pending result is shown, and loads
// an empty box and a threshold of one.

module ray_box_slab_test (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [rbst_pkg::CB-1:0]     i_origin_x,
    input  logic signed [rbst_pkg::CB-1:0]     i_origin_y,
    input  logic signed [rbst_pkg::CB-1:0]     i_origin_z,
    input  logic signed [rbst_pkg::CB-1:0]     i_dir_x,
    input  logic signed [rbst_pkg::CB-1:0]     i_dir_y,
    input  logic signed [rbst_pkg::CB-1:0]     i_dir_z,
    input  logic [rbst_pkg::LEN_W-1:0]         i_ray_length,
    input  logic                               i_cfg_we,
    input  logic [rbst_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [rbst_pkg::CB-1:0]            i_cfg_data,
    output logic                               o_valid,
    output logic                               o_hit
);
    import rbst_pkg::*;

    logic signed [CB-1:0]  r_box_lo [LANES];
    logic signed [CB-1:0]  r_box_hi [LANES];
    logic [THR_W-1:0]      r_thr;
    logic [TOTAL_LAT-1:0]  r_vld;
    logic signed [CB-1:0]  origin [LANES];
    logic signed [CB-1:0]  dir [LANES];
    t_lane_res             lane_res [LANES];

    assign o_busy = 1'b0;

    assign origin[0] = i_origin_x;
    assign origin[1] = i_origin_y;
    assign origin[2] = i_origin_z;
    assign dir[0]    = i_dir_x;
    assign dir[1]    = i_dir_y;
    assign dir[2]    = i_dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANES; k++) begin
                r_box_lo[k] <= $signed(MAX_MAG);
                r_box_hi[k] <= $signed(MIN_MAG);
            end
            r_thr <= THR_W'(1);
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_start & ~o_busy};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BOX_MIN_X: r_box_lo[0] <= $signed(i_cfg_data);
                    REG_BOX_MIN_Y: r_box_lo[1] <= $signed(i_cfg_data);
                    REG_BOX_MIN_Z: r_box_lo[2] <= $signed(i_cfg_data);
                    REG_BOX_MAX_X: r_box_hi[0] <= $signed(i_cfg_data);
                    REG_BOX_MAX_Y: r_box_hi[1] <= $signed(i_cfg_data);
                    REG_BOX_MAX_Z: r_box_hi[2] <= $signed(i_cfg_data);
                    REG_THRESHOLD: r_thr <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        rbst_lane u_lane (
            .i_clk    (i_clk),
            .i_origin (origin[g]),
            .i_dir    (dir[g]),
            .i_len    (i_ray_length),
            .i_lo     (r_box_lo[g]),
            .i_hi     (r_box_hi[g]),
            .i_thr    (r_thr),
            .o_res    (lane_res[g])
        );
    end

    rbst_merge u_merge (
        .i_clk (i_clk),
        .i_res (lane_res),
        .o_hit (o_hit)
    );

    assign o_valid = r_vld[TOTAL_LAT-1];

endmodule

`default_nettype wire

[sv/rbst_div.sv]
`default_nettype none

module rbst_div (
    input  logic                         i_clk,
    input  logic [rbst_pkg::NUM_W-1:0]   i_num,
    input  logic [rbst_pkg::CB-1:0]      i_den,
    output logic [rbst_pkg::NUM_W-1:0]   o_quo
);
    import rbst_pkg::*;

    // One quotient bit per stage; numerator bits shift out as quotient bits shift in.
    logic [NUM_W-1:0] r_nq  [NUM_W];
    logic [CB-1:0]    r_rem [NUM_W];
    logic [CB-1:0]    r_den [NUM_W];
    logic [NUM_W-1:0] n_nq  [NUM_W];
    logic [CB-1:0]    n_rem [NUM_W];
    logic [CB-1:0]    n_den [NUM_W];

    always_comb begin
        logic [NUM_W-1:0] nq_prev;
        logic [CB-1:0]    rem_prev;
        logic [CB-1:0]    den_prev;
        logic [CB:0]      sh;
        logic             ge;
        for (int k = 0; k < NUM_W; k++) begin
            if (k == 0) begin
                nq_prev  = i_num;
                rem_prev = '0;
                den_prev = i_den;
            end else begin
                nq_prev  = r_nq[k-1];
                rem_prev = r_rem[k-1];
                den_prev = r_den[k-1];
            end
            sh       = {rem_prev, nq_prev[NUM_W-1]};
            ge       = sh >= {1'b0, den_prev};
            n_rem[k] = ge ? CB'(sh - {1'b0, den_prev}) : sh[CB-1:0];
            n_nq[k]  = {nq_prev[NUM_W-2:0], ge};
            n_den[k] = den_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nq  <= n_nq;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_quo = r_nq[NUM_W-1];

endmodule

`default_nettype wire

[sv/rbst_lane.sv]
`default_nettype none

module rbst_lane (
    input  logic                               i_clk,
    input  logic signed [rbst_pkg::CB-1:0]     i_origin,
    input  logic signed [rbst_pkg::CB-1:0]     i_dir,
    input  logic [rbst_pkg::LEN_W-1:0]         i_len,
    input  logic signed [rbst_pkg::CB-1:0]     i_lo,
    input  logic signed [rbst_pkg::CB-1:0]     i_hi,
    input  logic [rbst_pkg::THR_W-1:0]         i_thr,
    output rbst_pkg::t_lane_res                o_res
);
    import rbst_pkg::*;

    logic [PROD_W-1:0]     r_prod;
    logic signed [CB:0]    r_dlo;
    logic signed [CB:0]    r_dhi;
    logic                  r_dneg;
    logic                  r_inside;

    logic [NUM_W-1:0]      r_num_lo;
    logic [NUM_W-1:0]      r_num_hi;
    logic [CB-1:0]         r_den;
    t_side                 r_side;
    t_side                 r_side_d [NUM_W];

    logic [NUM_W-1:0]      quo_lo;
    logic [NUM_W-1:0]      quo_hi;
    logic signed [CB-1:0]  r_t1;
    logic signed [CB-1:0]  r_t2;
    t_side                 r_side3;
    t_lane_res             r_res;

    logic [CB-1:0]         dir_mag;
    logic [PROD_W-FB-1:0]  p_shift;
    logic [CB-1:0]         lim;
    logic [CB-1:0]         dmag;
    logic [CB-1:0]         dlo_mag;
    logic [CB-1:0]         dhi_mag;
    t_side                 n_side;

    assign dir_mag = i_dir[CB-1] ? (~i_dir + CB'(1)) : i_dir;

    always_ff @(posedge i_clk) begin
        r_prod   <= PROD_W'(dir_mag) * PROD_W'(i_len);
        r_dlo    <= (CB+1)'(i_lo) - (CB+1)'(i_origin);
        r_dhi    <= (CB+1)'(i_hi) - (CB+1)'(i_origin);
        r_dneg   <= i_dir[CB-1];
        r_inside <= (i_origin >= i_lo) && (i_origin <= i_hi);
    end

    always_comb begin
        p_shift = r_prod[PROD_W-1:FB];
        lim     = r_dneg ? MIN_MAG : MAX_MAG;
        dmag    = (p_shift > (PROD_W-FB)'(lim)) ? lim : p_shift[CB-1:0];
        dlo_mag = r_dlo[CB] ? CB'(~r_dlo + (CB+1)'(1)) : r_dlo[CB-1:0];
        dhi_mag = r_dhi[CB] ? CB'(~r_dhi + (CB+1)'(1)) : r_dhi[CB-1:0];
        n_side.par     = (dmag == '0) || (dmag < CB'(i_thr));
        n_side.par_hit = r_inside;
        n_side.neg1    = r_dlo[CB] ^ r_dneg;
        n_side.neg2    = r_dhi[CB] ^ r_dneg;
    end

    always_ff @(posedge i_clk) begin
        r_num_lo <= NUM_W'(dlo_mag) << FB;
        r_num_hi <= NUM_W'(dhi_mag) << FB;
        r_den    <= dmag;
        r_side   <= n_side;
        r_side_d[0] <= r_side;
        for (int k = 1; k < NUM_W; k++) begin
            r_side_d[k] <= r_side_d[k-1];
        end
    end

    rbst_div u_div_lo (
        .i_clk (i_clk),
        .i_num (r_num_lo),
        .i_den (r_den),
        .o_quo (quo_lo)
    );

    rbst_div u_div_hi (
        .i_clk (i_clk),
        .i_num (r_num_hi),
        .i_den (r_den),
        .o_quo (quo_hi)
    );

    always_ff @(posedge i_clk) begin
        r_t1    <= sat_pack(r_side_d[NUM_W-1].neg1, quo_lo);
        r_t2    <= sat_pack(r_side_d[NUM_W-1].neg2, quo_hi);
        r_side3 <= r_side_d[NUM_W-1];
        if (r_side3.par) begin
            r_res.ok  <= r_side3.par_hit;
            r_res.tlo <= '0;
            r_res.thi <= $signed(MAX_MAG);
        end else begin
            r_res.ok  <= 1'b1;
            r_res.tlo <= (r_t1 > r_t2) ? r_t2 : r_t1;
            r_res.thi <= (r_t1 > r_t2) ? r_t1 : r_t2;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[sv/rbst_merge.sv]
`default_nettype none

module rbst_merge (
    input  logic                  i_clk,
    input  rbst_pkg::t_lane_res   i_res [rbst_pkg::LANES],
    output logic                  o_hit
);
    import rbst_pkg::*;

    logic                  r_ok;
    logic signed [CB-1:0]  r_tmin;
    logic signed [CB-1:0]  r_tmax;
    logic                  r_hit;
    logic                  n_ok;
    logic signed [CB-1:0]  n_tmin;
    logic signed [CB-1:0]  n_tmax;

    always_comb begin
        n_ok   = 1'b1;
        n_tmin = '0;
        n_tmax = $signed(MAX_MAG);
        for (int k = 0; k < LANES; k++) begin
            n_ok = n_ok & i_res[k].ok;
            if (i_res[k].tlo > n_tmin) begin
                n_tmin = i_res[k].tlo;
            end
            if (i_res[k].thi < n_tmax) begin
                n_tmax = i_res[k].thi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok   <= n_ok;
        r_tmin <= n_tmin;
        r_tmax <= n_tmax;
        r_hit  <= r_ok && (r_tmin <= r_tmax);
    end

    assign o_hit = r_hit;

endmodule

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb;
    import rbst_pkg::*;

    typedef struct packed {
        logic signed [CB-1:0] ox, oy, oz, dx, dy, dz;
        logic [LEN_W-1:0] len;
    } ray_t;

    typedef struct {
        ray_t ray;
        int   want;
    } ray_row_t;

    localparam int PREDICT = 2;
    localparam logic signed [CB-1:0] ONE = 32'sh0001_0000;
    localparam logic signed [CB-1:0] TEN = 32'sh000a_0000;
    localparam logic signed [CB-1:0] TWENTY = 32'sh0014_0000;
    localparam logic signed [CB-1:0] FIFTEEN = 32'sh000f_0000;
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(32'h0001_0000);
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    logic i_clk = 1'b0;
    logic i_rst_n, i_start, o_busy, i_cfg_we, o_valid, o_hit;
    logic signed [CB-1:0] i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z;
    logic [LEN_W-1:0] i_ray_length;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CB-1:0] i_cfg_data;
    int typed_want;

    longint box_lo[3], box_hi[3];
    longint unsigned par_thr;
    logic hit_queue[$];
    int errors = 0;

    ray_box_slab_test dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint clamp_q16(input logic neg, input longint unsigned mag);
        if (!neg) return (mag > longint'(COORD_MAX)) ? COORD_MAX : longint'(mag);
        return (mag > 64'd2147483648) ? COORD_MIN : -longint'(mag);
    endfunction

    function automatic longint slab_t(input longint b, input longint o, input logic dneg,
                                      input longint unsigned dmag);
        longint diff;
        longint unsigned m;
        diff = b - o;
        m = (diff < 0) ? longint'(-diff) : longint'(diff);
        return clamp_q16((diff < 0) != dneg, (m << FB) / dmag);
    endfunction

    function automatic logic ray_hits_box(input ray_t r);
        longint o[3], d[3], sd, t1, t2, tmp, tmin, tmax;
        longint unsigned dm, dmag;
        o = '{longint'(r.ox), longint'(r.oy), longint'(r.oz)};
        d = '{longint'(r.dx), longint'(r.dy), longint'(r.dz)};
        tmin = 0;
        tmax = COORD_MAX;
        for (int a = 0; a < 3; a++) begin
            dm = (d[a] < 0) ? longint'(-d[a]) : longint'(d[a]);
            sd = clamp_q16(d[a] < 0, (dm * longint'(r.len)) >> FB);
            dmag = (sd < 0) ? longint'(-sd) : longint'(sd);
            if (dmag == 0 || dmag < par_thr) begin
                if (o[a] < box_lo[a] || o[a] > box_hi[a]) return 1'b0;
            end else begin
                t1 = slab_t(box_lo[a], o[a], sd < 0, dmag);
                t2 = slab_t(box_hi[a], o[a], sd < 0, dmag);
                if (t1 > t2) begin
                    tmp = t1;
                    t1 = t2;
                    t2 = tmp;
                end
                if (t1 > tmin) tmin = t1;
                if (t2 < tmax) tmax = t2;
                if (tmin > tmax) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) begin
            if (typed_want != PREDICT) hit_queue.push_back(typed_want[0]);
            else hit_queue.push_back(ray_hits_box({i_origin_x, i_origin_y, i_origin_z,
                                                   i_dir_x, i_dir_y, i_dir_z, i_ray_length}));
        end
        if (i_rst_n && o_valid) begin
            if (hit_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual hit=%0b", $time, o_hit);
                errors++;
            end else if (hit_queue[0] !== o_hit) begin
                $display("%0t: hit mismatch, expected %0b, actual %0b", $time, hit_queue[0],
                         o_hit);
                errors++;
                void'(hit_queue.pop_front());
            end else begin
                void'(hit_queue.pop_front());
            end
        end
    end

    task automatic send_ray(input ray_t r, input int want);
        i_start <= 1'b1;
        {i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z, i_ray_length} <= r;
        typed_want <= want;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CB-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx <= REG_BOX_MIN_Z) box_lo[idx] = longint'($signed(data));
        else if (idx <= REG_BOX_MAX_Z) box_hi[idx - REG_BOX_MAX_X] = longint'($signed(data));
        else if (idx == REG_THRESHOLD) par_thr = data[THR_W-1:0];
    endtask

    task automatic drain;
        i_start <= 1'b0;
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (TOTAL_LAT + 4) @(posedge i_clk);
    endtask

    function automatic logic signed [CB-1:0] pick_coord(input longint c);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return ($urandom_range(0, 1)) ? MAX_MAG : MIN_MAG;
            2: return CB'(c) + $signed(CB'($urandom_range(0, 8))) - 4;
            default: return $signed(CB'($urandom_range(0, 32'h0028_0000))) - TWENTY;
        endcase
    endfunction

    function automatic logic signed [CB-1:0] pick_dir();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 0;
            2: return $signed(CB'($urandom_range(0, 6))) - 3;
            3: return ($urandom_range(0, 1)) ? MAX_MAG : MIN_MAG;
            default: return $signed(CB'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 4))
            0: return LEN_W'($urandom);
            1: return ($urandom_range(0, 1)) ? '0 : '1;
            2: return LEN_ONE;
            default: return LEN_W'($urandom_range(0, 32'h0008_0000));
        endcase
    endfunction

    task automatic set_box(input int kind);
        logic signed [CB-1:0] a, b;
        for (int i = 0; i < 3; i++) begin
            a = $signed(CB'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
            b = $signed(CB'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
            case (kind)
                0: begin
                    a = MAX_MAG;
                    b = MIN_MAG;
                end
                1: begin
                    a = MIN_MAG;
                    b = MAX_MAG;
                end
                4: begin
                    a = $urandom;
                    b = $urandom;
                end
                default: if (a > b) {a, b} = {b, a};
            endcase
            write_reg(REG_BOX_MIN_X + IDX_W'(i), a);
            write_reg(REG_BOX_MAX_X + IDX_W'(i), b);
        end
        case (kind)
            1: write_reg(REG_THRESHOLD, 32'h0);
            3: write_reg(REG_THRESHOLD, 32'h0000_ffff);
            default: write_reg(REG_THRESHOLD, $urandom);
        endcase
        write_reg(IDX_W'(7), $urandom);
        i_cfg_we <= 1'b0;
    endtask

    ray_row_t rows[$];

    initial begin
        ray_t r;
        int burst;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        typed_want <= PREDICT;
        {i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z, i_ray_length} <= '0;
        for (int i = 0; i < 3; i++) begin
            box_lo[i] = COORD_MAX;
            box_hi[i] = COORD_MIN;
        end
        par_thr = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The box is empty after reset, so a ray of zero length misses.
        send_ray('{0, 0, 0, ONE, ONE, ONE, '0}, 0);
        send_ray('{TEN, -TEN, 0, MAX_MAG, MIN_MAG, 0, '0}, 0);
        send_ray('{0, 0, 0, ONE, 0, 0, LEN_ONE}, PREDICT);
        drain();
        for (int i = 0; i < 3; i++) begin
            write_reg(REG_BOX_MIN_X + IDX_W'(i), -TEN);
            write_reg(REG_BOX_MAX_X + IDX_W'(i), TEN);
        end
        write_reg(REG_THRESHOLD, 32'h0000_0001);
        i_cfg_we <= 1'b0;

        rows = '{
            '{'{0, 0, 0, ONE, 0, 0, LEN_ONE}, 1},
            '{'{TWENTY, 0, 0, 0, 0, 0, LEN_ONE}, 0},
            '{'{TEN, TEN, -TEN, 0, 0, 0, LEN_ONE}, 1},
            '{'{-TWENTY, 0, 0, ONE, 0, 0, LEN_ONE}, 1},
            '{'{TWENTY, 0, 0, ONE, 0, 0, LEN_ONE}, 0},
            '{'{-TWENTY, 0, 0, -ONE, 0, 0, LEN_ONE}, 0},
            '{'{-TWENTY, -TWENTY, -TWENTY, ONE, ONE, ONE, LEN_ONE}, 1},
            '{'{-TWENTY, FIFTEEN, 0, ONE, 0, 0, LEN_ONE}, 0},
            '{'{MAX_MAG, MAX_MAG, MAX_MAG, 1, 1, 1, LEN_W'(1)}, 0},
            '{'{0, 0, 0, 0, 0, 0, '0}, 1},
            '{'{0, 0, 0, MIN_MAG, MIN_MAG, MIN_MAG, '1}, PREDICT},
            '{'{MIN_MAG, MIN_MAG, MIN_MAG, MAX_MAG, MAX_MAG, MAX_MAG, '1}, PREDICT},
            '{'{MAX_MAG, 0, MIN_MAG, MIN_MAG, 1, MAX_MAG, '1}, PREDICT},
            '{'{0, TEN, 0, 1, -1, 1, LEN_ONE}, PREDICT},
            '{'{-TWENTY, 0, 0, 32'sh0000_8000, 3, -3, LEN_W'(32'h0000_8000)}, PREDICT},
            '{'{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                LEN_W'($urandom)}, PREDICT}
        };
        foreach (rows[i]) send_ray(rows[i].ray, rows[i].want);
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            set_box(phase % 5);
            for (int n = 0; n < 172; ) begin
                burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
                for (int k = 0; k < burst && n < 172; k++, n++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             LEN_W'($urandom)};
                    end else begin
                        r.ox = pick_coord(($urandom_range(0, 1)) ? box_lo[0] : box_hi[0]);
                        r.oy = pick_coord(($urandom_range(0, 1)) ? box_lo[1] : box_hi[1]);
                        r.oz = pick_coord(($urandom_range(0, 1)) ? box_lo[2] : box_hi[2]);
                        r.dx = pick_dir();
                        r.dy = pick_dir();
                        r.dz = pick_dir();
                        r.len = pick_len();
                    end
                    send_ray(r, PREDICT);
                end
                if ($urandom_range(0, 2) != 0) begin
                    i_start <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("[ray_box_slab_test] OK");
        end else begin
            $display("[ray_box_slab_test] ERROR");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("[ray_box_slab_test] ERROR");
        $finish;
    end
endmodule

`default_nettype wire
